@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL file that carries checks.
// Each macro expects clk in scope at the point of use; DEE_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge while out of reset
`define DEE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dee assertion failed");

// Check on every rising edge, reset included
`define DEE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dee assertion failed");

`endif

@@ rtl/dee_pkg.sv @@
// Types and constants of the dual EEPROM register device.
// No dependencies; used by the transfer sequencer and the top level.
package dee_pkg;

  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_SET_DATA      = 3'd1,
    OP_SET_ADDR      = 3'd2,
    OP_COMMAND       = 3'd3,
    OP_READ_BUSY     = 3'd4,
    OP_READ_RESULT   = 3'd5,
    OP_READ_ACTIVITY = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    XS_CLEAR,
    XS_IDLE,
    XS_XFER,
    XS_TAIL
  } xfer_state_t;

  localparam logic [31:0] CMD_RD_INT = 32'd0;
  localparam logic [31:0] CMD_RD_EXT = 32'd1;
  localparam logic [31:0] CMD_WR_INT = 32'd2;
  localparam logic [31:0] CMD_WR_EXT = 32'd3;

  localparam logic [31:0] WORD_ONES   = 32'hFFFF_FFFF;
  localparam logic [7:0]  BYTE_ERASED = 8'hFF;
  localparam logic [15:0] BUSY_TICKS_RST = 16'd250;

  // Request from the register file to the byte sequencer
  typedef struct packed {
    logic go;
    logic wr;
    logic ext;
  } xfer_req_t;

  // Sequencer status back to the register file
  typedef struct packed {
    logic idle;
    logic done;
  } xfer_stat_t;

endpackage

@@ rtl/dee_store.sv @@
// Byte-wide single-port store with registered read data.
// No dependencies; instantiated twice by the top level.
module dee_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/dee_xfer.sv @@
// Byte sequencer: one shared pointer incrementer with wrap drives both stores,
// four byte accesses per command, plus the erase sweep after reset. Uses dee_pkg.
module dee_xfer #(
  parameter int INTERNAL_BYTES = 8192,
  parameter int EXTERNAL_BYTES = 65536,
  parameter int PW             = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dee_pkg::xfer_req_t   req,
  input  logic [31:0]          addr,
  input  logic [31:0]          wdata,
  input  logic [7:0]           int_rdata,
  input  logic [7:0]           ext_rdata,
  output logic [PW-1:0]        mem_addr,
  output logic [7:0]           mem_wdata,
  output logic                 int_we,
  output logic                 ext_we,
  output logic [31:0]          rd_word,
  output dee_pkg::xfer_stat_t  stat
);

  localparam int MAX_BYTES = (INTERNAL_BYTES > EXTERNAL_BYTES) ? INTERNAL_BYTES
                                                               : EXTERNAL_BYTES;
  localparam logic [PW-1:0] CLR_LAST = PW'(MAX_BYTES - 1);
  localparam logic [PW-1:0] INT_LAST = PW'(INTERNAL_BYTES - 1);
  localparam logic [PW-1:0] EXT_LAST = PW'(EXTERNAL_BYTES - 1);
  localparam logic [PW:0]   INT_LIM  = (PW+1)'(INTERNAL_BYTES);
  localparam logic [PW:0]   EXT_LIM  = (PW+1)'(EXTERNAL_BYTES);

  dee_pkg::xfer_state_t st_r, st_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [31:0]   word_r, word_nxt;
  logic          wr_r, wr_nxt;
  logic          ext_r, ext_nxt;
  logic [PW-1:0] wrap_last;
  logic [PW-1:0] ptr_inc;
  logic [7:0]    rbyte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= dee_pkg::XS_CLEAR;
      ptr_r <= '0;
      cnt_r <= '0;
      wr_r  <= 1'b0;
      ext_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_nxt;
      wr_r  <= wr_nxt;
      ext_r <= ext_nxt;
    end
    word_r <= word_nxt;
  end

  // Shared step unit: next byte address, wrapping at the end of the store
  assign wrap_last = ext_r ? EXT_LAST : INT_LAST;
  assign ptr_inc   = (ptr_r == wrap_last) ? '0 : PW'(ptr_r + 1'b1);
  assign rbyte     = ext_r ? ext_rdata : int_rdata;
  assign rd_word   = {rbyte, word_r[31:8]};
  assign mem_addr  = ptr_r;

  always_comb begin
    st_nxt    = st_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    word_nxt  = word_r;
    wr_nxt    = wr_r;
    ext_nxt   = ext_r;
    int_we    = 1'b0;
    ext_we    = 1'b0;
    mem_wdata = word_r[7:0];
    stat      = '0;
    case (st_r)
      dee_pkg::XS_CLEAR: begin
        mem_wdata = dee_pkg::BYTE_ERASED;
        int_we    = {1'b0, ptr_r} < INT_LIM;
        ext_we    = {1'b0, ptr_r} < EXT_LIM;
        ptr_nxt   = PW'(ptr_r + 1'b1);
        if (ptr_r == CLR_LAST) begin
          ptr_nxt = '0;
          st_nxt  = dee_pkg::XS_IDLE;
        end
      end
      dee_pkg::XS_IDLE: begin
        stat.idle = 1'b1;
        if (req.go) begin
          ptr_nxt  = addr[PW-1:0];
          cnt_nxt  = '0;
          wr_nxt   = req.wr;
          ext_nxt  = req.ext;
          word_nxt = wdata;
          st_nxt   = dee_pkg::XS_XFER;
        end
      end
      dee_pkg::XS_XFER: begin
        int_we  = wr_r & ~ext_r;
        ext_we  = wr_r & ext_r;
        ptr_nxt = ptr_inc;
        cnt_nxt = 2'(cnt_r + 2'd1);
        // writes shift the next byte down; reads shift the arriving byte in at the top
        if (wr_r || cnt_r != 2'd0) begin
          word_nxt = rd_word;
        end
        if (cnt_r == 2'd3) begin
          st_nxt = dee_pkg::XS_TAIL;
        end
      end
      dee_pkg::XS_TAIL: begin
        stat.done = 1'b1;
        st_nxt    = dee_pkg::XS_IDLE;
      end
      default: begin
        st_nxt = dee_pkg::XS_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/dual_eeprom_register_device.sv @@
// Register and read requests are answered through the output register. An in-range
// command makes four byte accesses on the shared byte port of the store, then a
// tail step to collect the last read byte, and accepts no request meanwhile. A command
// at or past the end of a store is answered without any byte access. Reset: an
// erase sweep writes 0xFF through both stores, max(INTERNAL_BYTES, EXTERNAL_BYTES)
// addresses (65536 by default), with in_tready low; cfg writes still land.
module dual_eeprom_register_device #(
  parameter int INTERNAL_BYTES = 8192,
  parameter int EXTERNAL_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_value
  output logic [0:0]  out_tuser,  // [0] rejected
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int IAW = $clog2(INTERNAL_BYTES);
  localparam int EAW = $clog2(EXTERNAL_BYTES);
  localparam int PW  = (IAW > EAW) ? IAW : EAW;
  localparam logic [31:0] INT_SIZE = 32'(INTERNAL_BYTES);
  localparam logic [31:0] EXT_SIZE = 32'(EXTERNAL_BYTES);

  logic [15:0] busy_ticks_r;
  logic [31:0] data_r, addr_r, result_r, result_nxt;
  logic        busy_r, act_r;
  logic [15:0] ticks_r;
  logic        pend_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_rej_r;
  logic        req_wr_r;

  logic          in_fire;
  logic          out_fire;
  dee_pkg::op_t  op;
  logic          cmd_known;
  logic          cmd_oob;
  logic          launch;
  dee_pkg::xfer_req_t  req;
  dee_pkg::xfer_stat_t stat;
  logic [PW-1:0] mem_addr;
  logic [7:0]    mem_wdata, int_rdata, ext_rdata;
  logic          int_we, ext_we;
  logic [31:0]   rd_word;
  logic [31:0]   rsp_data;
  logic          rsp_rej;

  assign op        = dee_pkg::op_t'(in_tuser);
  assign in_tready = stat.idle & ~pend_r & (~out_valid_r | out_tready);
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_valid_r & out_tready;

  assign cmd_known = (in_tdata == dee_pkg::CMD_RD_INT) || (in_tdata == dee_pkg::CMD_RD_EXT) ||
                     (in_tdata == dee_pkg::CMD_WR_INT) || (in_tdata == dee_pkg::CMD_WR_EXT);
  assign cmd_oob   = in_tdata[0] ? (addr_r >= EXT_SIZE) : (addr_r >= INT_SIZE);
  assign launch    = in_fire && op == dee_pkg::OP_COMMAND && cmd_known && !cmd_oob;

  assign req.go  = launch;
  assign req.wr  = in_tdata[1];
  assign req.ext = in_tdata[0];

  // Immediate response for everything but an in-range command
  always_comb begin
    rsp_data   = '0;
    rsp_rej    = 1'b0;
    result_nxt = result_r;
    case (op)
      dee_pkg::OP_COMMAND: begin
        rsp_rej = ~cmd_known;
        if (cmd_known && cmd_oob && !in_tdata[1]) begin
          result_nxt = dee_pkg::WORD_ONES;
        end
      end
      dee_pkg::OP_READ_BUSY:     rsp_data = {31'd0, busy_r};
      dee_pkg::OP_READ_RESULT:   rsp_data = result_r;
      dee_pkg::OP_READ_ACTIVITY: rsp_data = {31'd0, act_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_ticks_r <= dee_pkg::BUSY_TICKS_RST;
      data_r       <= '0;
      addr_r       <= '0;
      result_r     <= '0;
      busy_r       <= 1'b0;
      ticks_r      <= '0;
      act_r        <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        busy_ticks_r <= cfg_wdata;
      end
      if (stat.done || (in_fire && !launch)) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (stat.done) begin
        pend_r <= 1'b0;
        if (!req_wr_r) begin
          result_r <= rd_word;
        end
      end
      if (in_fire) begin
        result_r <= result_nxt;
        case (op)
          dee_pkg::OP_TICK: begin
            if (busy_r) begin
              if (ticks_r <= 16'd1) begin
                busy_r  <= 1'b0;
                ticks_r <= '0;
              end else begin
                ticks_r <= ticks_r - 16'd1;
              end
            end
          end
          dee_pkg::OP_SET_DATA: data_r <= in_tdata;
          dee_pkg::OP_SET_ADDR: addr_r <= in_tdata;
          dee_pkg::OP_COMMAND: begin
            if (cmd_known) begin
              act_r   <= 1'b1;
              busy_r  <= 1'b1;
              ticks_r <= busy_ticks_r;
              pend_r  <= launch;
            end
          end
          dee_pkg::OP_READ_ACTIVITY: act_r <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // Remember the direction of the command in flight
  always_ff @(posedge clk) begin
    if (launch) begin
      req_wr_r <= req.wr;
    end
  end

  // Output payload: hold while a request waits downstream
  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_data_r <= '0;
      out_rej_r  <= 1'b0;
    end else if (in_fire && !launch) begin
      out_data_r <= rsp_data;
      out_rej_r  <= rsp_rej;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_rej_r;

  dee_xfer #(
    .INTERNAL_BYTES (INTERNAL_BYTES),
    .EXTERNAL_BYTES (EXTERNAL_BYTES),
    .PW             (PW)
  ) u_xfer (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .addr      (addr_r),
    .wdata     (data_r),
    .int_rdata (int_rdata),
    .ext_rdata (ext_rdata),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .int_we    (int_we),
    .ext_we    (ext_we),
    .rd_word   (rd_word),
    .stat      (stat)
  );

  dee_store #(
    .DEPTH (INTERNAL_BYTES),
    .AW    (IAW)
  ) u_int_store (
    .clk   (clk),
    .we    (int_we),
    .addr  (mem_addr[IAW-1:0]),
    .wdata (mem_wdata),
    .rdata (int_rdata)
  );

  dee_store #(
    .DEPTH (EXTERNAL_BYTES),
    .AW    (EAW)
  ) u_ext_store (
    .clk   (clk),
    .we    (ext_we),
    .addr  (mem_addr[EAW-1:0]),
    .wdata (mem_wdata),
    .rdata (ext_rdata)
  );

`include "assert_macros.svh"

  `DEE_ASSERT(a_no_accept_in_flight, pend_r |-> !in_tready)
  `DEE_ASSERT(a_done_only_in_flight, stat.done |-> pend_r)
  `DEE_ASSERT(a_idle_means_no_count, !busy_r |-> ticks_r == 16'd0)
  `DEE_ASSERT(a_cmd_sets_busy, (in_fire && op == dee_pkg::OP_COMMAND && cmd_known)
                               |=> (busy_r && act_r))

endmodule
